/* rtl/trt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_pkg
// Shared types and constants for the touch report tracker.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int AGE_BITS_DEF   = 16;

  localparam int BYTE_BITS      = 8;
  localparam int NIBBLE_SHIFT   = 4;
  localparam logic [7:0] LOW_NIBBLE = 8'h0F;
  localparam int RAW_COORD_BITS = BYTE_BITS + NIBBLE_SHIFT;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int TIMEOUT_BITS   = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOUCH_ID = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [7:0]  TOUCH_ID_RST = 8'd1;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  // status byte bit positions
  localparam int ST_DETECT   = 7;
  localparam int ST_PRESS    = 6;
  localparam int ST_RELEASE  = 5;
  localparam int ST_SUPPRESS = 1;

  localparam logic [1:0] MODE_POLL_BEGIN = 2'd0;
  localparam logic [1:0] MODE_MESSAGE    = 2'd1;
  localparam logic [1:0] MODE_POLL_END   = 2'd2;
  localparam logic [1:0] MODE_TICK       = 2'd3;

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_REFUSE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OPEN = 2'd1,
    PH_HALT = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic detect;
    logic press;
    logic rel;
    logic suppress;
  } flags_t;

endpackage

/* rtl/touch_report_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_tracker
// Follows one touch contact through poll, message and tick items.
// ----------------------------------------------------------------------------
// One item is taken per clock while in_stall is low. Every item is decoded
// and applied to the contact state in the cycle it is accepted; any result
// is registered for the out_ port. Results pass through an output register
// plus one skid entry, so the block keeps taking items while a result waits;
// in_stall rises only when both entries hold results. A message with kind 1
// on the output was refused and must be sent again in a later poll.
module touch_report_tracker #(
  parameter int COORD_BITS = trt_pkg::COORD_BITS_DEF,
  parameter int AGE_BITS   = trt_pkg::AGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [trt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [trt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_mode,
  input  logic [7:0]                         in_msg_report_id,
  input  logic [7:0]                         in_status_byte,
  input  logic [7:0]                         in_x_high,
  input  logic [7:0]                         in_y_high,
  input  logic [7:0]                         in_xy_low,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_kind,
  output logic [COORD_BITS-1:0]              out_point_x,
  output logic [COORD_BITS-1:0]              out_point_y,
  output logic                               out_point_down
);

  trt_pkg::flags_t       flags;
  logic [COORD_BITS-1:0] msg_x;
  logic [COORD_BITS-1:0] msg_y;
  logic                  item_acc;
  logic                  res_valid;
  logic                  res_kind;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic                  res_down;
  logic                  full;

  assign in_stall = full;
  assign item_acc = in_valid && !full;

  trt_decode #(.COORD_BITS(COORD_BITS)) u_decode (
    .status_byte (in_status_byte),
    .x_high      (in_x_high),
    .y_high      (in_y_high),
    .xy_low      (in_xy_low),
    .flags       (flags),
    .msg_x       (msg_x),
    .msg_y       (msg_y)
  );

  trt_core #(.COORD_BITS(COORD_BITS), .AGE_BITS(AGE_BITS)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .item_acc      (item_acc),
    .mode          (in_mode),
    .msg_report_id (in_msg_report_id),
    .flags         (flags),
    .msg_x         (msg_x),
    .msg_y         (msg_y),
    .res_valid     (res_valid),
    .res_kind      (res_kind),
    .res_x         (res_x),
    .res_y         (res_y),
    .res_down      (res_down)
  );

  trt_outbuf #(.COORD_BITS(COORD_BITS)) u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_kind       (res_kind),
    .res_x          (res_x),
    .res_y          (res_y),
    .res_down       (res_down),
    .full           (full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_down (out_point_down)
  );

endmodule

/* rtl/trt_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_decode
// Unpacks status flags and the packed x/y coordinate bytes of a message.
// ----------------------------------------------------------------------------
module trt_decode #(
  parameter int COORD_BITS = trt_pkg::COORD_BITS_DEF
) (
  input  logic [7:0]            status_byte,
  input  logic [7:0]            x_high,
  input  logic [7:0]            y_high,
  input  logic [7:0]            xy_low,
  output trt_pkg::flags_t       flags,
  output logic [COORD_BITS-1:0] msg_x,
  output logic [COORD_BITS-1:0] msg_y
);

  localparam int RAW = trt_pkg::RAW_COORD_BITS;

  logic [7:0]                x_nib;
  logic [7:0]                y_nib;
  logic [RAW-1:0]            raw_x;
  logic [RAW-1:0]            raw_y;
  logic [RAW+COORD_BITS-1:0] ext_x;
  logic [RAW+COORD_BITS-1:0] ext_y;

  assign flags.detect   = status_byte[trt_pkg::ST_DETECT];
  assign flags.press    = status_byte[trt_pkg::ST_PRESS];
  assign flags.rel      = status_byte[trt_pkg::ST_RELEASE];
  assign flags.suppress = status_byte[trt_pkg::ST_SUPPRESS];

  assign x_nib = (xy_low >> trt_pkg::NIBBLE_SHIFT) & trt_pkg::LOW_NIBBLE;
  assign y_nib = xy_low & trt_pkg::LOW_NIBBLE;
  assign raw_x = {x_high, x_nib[trt_pkg::NIBBLE_SHIFT-1:0]};
  assign raw_y = {y_high, y_nib[trt_pkg::NIBBLE_SHIFT-1:0]};

  // zero-extend, then keep the low COORD_BITS
  assign ext_x = {{COORD_BITS{1'b0}}, raw_x};
  assign ext_y = {{COORD_BITS{1'b0}}, raw_y};
  assign msg_x = ext_x[COORD_BITS-1:0];
  assign msg_y = ext_y[COORD_BITS-1:0];

endmodule

/* rtl/trt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_core
// Contact state, configuration registers and per-item update logic.
// ----------------------------------------------------------------------------
module trt_core #(
  parameter int COORD_BITS = trt_pkg::COORD_BITS_DEF,
  parameter int AGE_BITS   = trt_pkg::AGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [trt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [trt_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               item_acc,
  input  logic [1:0]                         mode,
  input  logic [7:0]                         msg_report_id,
  input  trt_pkg::flags_t                    flags,
  input  logic [COORD_BITS-1:0]              msg_x,
  input  logic [COORD_BITS-1:0]              msg_y,
  output logic                               res_valid,
  output logic                               res_kind,
  output logic [COORD_BITS-1:0]              res_x,
  output logic [COORD_BITS-1:0]              res_y,
  output logic                               res_down
);

  localparam int CMP_W = (AGE_BITS > trt_pkg::TIMEOUT_BITS) ? AGE_BITS
                                                            : trt_pkg::TIMEOUT_BITS;

  logic                              enable_r;
  logic [7:0]                        touch_id_r;
  logic [trt_pkg::TIMEOUT_BITS-1:0]  timeout_r;

  logic                  down_r, down_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic                  pend_rel_r, pend_rel_nxt;
  logic                  pend_press_r, pend_press_nxt;
  logic [COORD_BITS-1:0] pend_x_r, pend_x_nxt;
  logic [COORD_BITS-1:0] pend_y_r, pend_y_nxt;
  logic [AGE_BITS-1:0]   age_r, age_nxt;
  logic                  pressed_r, pressed_nxt;
  trt_pkg::phase_t       phase_r, phase_nxt;

  logic [CMP_W-1:0] age_ext;
  logic [CMP_W-1:0] timeout_ext;
  logic             stuck;

  assign age_ext     = CMP_W'(age_r);
  assign timeout_ext = CMP_W'(timeout_r);
  assign stuck       = down_r && (age_ext > timeout_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      touch_id_r <= trt_pkg::TOUCH_ID_RST;
      timeout_r  <= trt_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        trt_pkg::REG_ENABLE:   enable_r   <= cfg_wdata[0];
        trt_pkg::REG_TOUCH_ID: touch_id_r <= cfg_wdata[7:0];
        trt_pkg::REG_TIMEOUT:  timeout_r  <= cfg_wdata[trt_pkg::TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    down_nxt       = down_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    pend_rel_nxt   = pend_rel_r;
    pend_press_nxt = pend_press_r;
    pend_x_nxt     = pend_x_r;
    pend_y_nxt     = pend_y_r;
    age_nxt        = age_r;
    pressed_nxt    = pressed_r;
    phase_nxt      = phase_r;
    res_valid      = 1'b0;
    res_kind       = trt_pkg::KIND_POINT;
    res_x          = cur_x_r;
    res_y          = cur_y_r;
    res_down       = 1'b0;

    if (item_acc) begin
      case (mode)
        trt_pkg::MODE_POLL_BEGIN: begin
          if (!enable_r) begin
            phase_nxt = trt_pkg::PH_DONE;
            res_valid = 1'b1;
          end else if (pend_rel_r) begin
            pend_rel_nxt = 1'b0;
            down_nxt     = 1'b0;
            phase_nxt    = trt_pkg::PH_DONE;
            res_valid    = 1'b1;
          end else if (pend_press_r) begin
            pend_press_nxt = 1'b0;
            cur_x_nxt      = pend_x_r;
            cur_y_nxt      = pend_y_r;
            down_nxt       = 1'b1;
            age_nxt        = '0;
            phase_nxt      = trt_pkg::PH_DONE;
            res_valid      = 1'b1;
            res_x          = pend_x_r;
            res_y          = pend_y_r;
            res_down       = 1'b1;
          end else begin
            pressed_nxt = 1'b0;
            phase_nxt   = trt_pkg::PH_OPEN;
          end
        end
        trt_pkg::MODE_MESSAGE: begin
          if (!enable_r || phase_r != trt_pkg::PH_OPEN) begin
            res_valid = 1'b1;
            res_kind  = trt_pkg::KIND_REFUSE;
            res_x     = '0;
            res_y     = '0;
          end else if (msg_report_id == touch_id_r) begin
            age_nxt = '0;
            if (flags.suppress) begin
              down_nxt = 1'b0;
            end else if (flags.detect) begin
              if (flags.press && down_r) begin
                // press while down: hold it for the next poll
                down_nxt       = 1'b0;
                pend_press_nxt = 1'b1;
                pend_x_nxt     = msg_x;
                pend_y_nxt     = msg_y;
                phase_nxt      = trt_pkg::PH_HALT;
              end else begin
                cur_x_nxt = msg_x;
                cur_y_nxt = msg_y;
                if (!down_r) pressed_nxt = 1'b1;
                down_nxt  = 1'b1;
              end
            end else if (flags.rel) begin
              if (pressed_r) begin
                pend_rel_nxt = 1'b1;
                phase_nxt    = trt_pkg::PH_HALT;
              end else begin
                down_nxt = 1'b0;
              end
            end
          end
        end
        trt_pkg::MODE_POLL_END: begin
          phase_nxt = trt_pkg::PH_IDLE;
          if (phase_r == trt_pkg::PH_OPEN || phase_r == trt_pkg::PH_HALT) begin
            if (stuck) begin
              down_nxt       = 1'b0;
              pend_rel_nxt   = 1'b0;
              pend_press_nxt = 1'b0;
            end
            res_valid = 1'b1;
            res_down  = down_r && !stuck;
          end
        end
        trt_pkg::MODE_TICK: begin
          if (age_r != {AGE_BITS{1'b1}}) age_nxt = age_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r       <= 1'b0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      pend_rel_r   <= 1'b0;
      pend_press_r <= 1'b0;
      pend_x_r     <= '0;
      pend_y_r     <= '0;
      age_r        <= '0;
      pressed_r    <= 1'b0;
      phase_r      <= trt_pkg::PH_IDLE;
    end else begin
      down_r       <= down_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      pend_rel_r   <= pend_rel_nxt;
      pend_press_r <= pend_press_nxt;
      pend_x_r     <= pend_x_nxt;
      pend_y_r     <= pend_y_nxt;
      age_r        <= age_nxt;
      pressed_r    <= pressed_nxt;
      phase_r      <= phase_nxt;
    end
  end

endmodule

/* rtl/trt_outbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt_outbuf
// Output register with one skid entry; stalls the input only when both hold.
// ----------------------------------------------------------------------------
module trt_outbuf #(
  parameter int COORD_BITS = trt_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  logic                  res_kind,
  input  logic [COORD_BITS-1:0] res_x,
  input  logic [COORD_BITS-1:0] res_y,
  input  logic                  res_down,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic                  out_point_down
);

  localparam int W = 2 * COORD_BITS + 2;

  logic         out_v_r;
  logic [W-1:0] out_d_r;
  logic         skid_v_r;
  logic [W-1:0] skid_d_r;
  logic [W-1:0] res_d;
  logic         slot_free;

  assign res_d     = {res_kind, res_x, res_y, res_down};
  assign slot_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_d_r <= skid_v_r ? skid_d_r : res_d;
    end else if (res_valid) begin
      skid_d_r <= res_d;
    end
  end

  assign full           = skid_v_r;
  assign out_valid      = out_v_r;
  assign out_kind       = out_d_r[W-1];
  assign out_point_x    = out_d_r[W-2 -: COORD_BITS];
  assign out_point_y    = out_d_r[COORD_BITS:1];
  assign out_point_down = out_d_r[0];

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives poll, message and tick items into the touch report tracker under
// varied handshake pressure and register settings. A scoreboard keeps its
// own copy of the contact state, predicts each point report or refusal, and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb;
  import trt_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int AGE_W   = AGE_BITS_DEF;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               down;
  } point_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] msg_id;
    logic [7:0] status;
    logic [7:0] x_high;
    logic [7:0] y_high;
    logic [7:0] xy_low;
  } msg_item_t;

  class touch_scoreboard;
    logic               en;
    logic [7:0]         touch_id;
    logic [15:0]        stuck_limit;
    logic               down, pend_release, pend_press, fresh_press;
    logic [COORD_W-1:0] cur_x, cur_y, pend_x, pend_y;
    logic [AGE_W-1:0]   age;
    phase_t             phase;
    point_t             expected_q[$];
    int                 fail_count;

    function new();
      en = 1'b0;
      touch_id = TOUCH_ID_RST;
      stuck_limit = TIMEOUT_RST;
      down = 1'b0;
      pend_release = 1'b0;
      pend_press = 1'b0;
      fresh_press = 1'b0;
      cur_x = '0;
      cur_y = '0;
      pend_x = '0;
      pend_y = '0;
      age = '0;
      phase = PH_IDLE;
      fail_count = 0;
    endfunction

    function void set_config(logic en_v, logic [7:0] id_v, logic [15:0] lim_v);
      en = en_v;
      touch_id = id_v;
      stuck_limit = lim_v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function point_t make_point(logic k, logic [COORD_W-1:0] px,
                                logic [COORD_W-1:0] py, logic d);
      point_t p;
      p.kind = k;
      p.x = px;
      p.y = py;
      p.down = d;
      return p;
    endfunction

    // Apply one accepted item to the contact state; queue its report if any.
    function void note_item(msg_item_t it);
      logic [COORD_W-1:0] nx, ny;
      logic               halt;
      phase_t             was;
      halt = 1'b0;
      case (it.mode)
        MODE_POLL_BEGIN: begin
          if (!en) begin
            phase = PH_DONE;
            expected_q.push_back(make_point(KIND_POINT, cur_x, cur_y, 1'b0));
          end else if (pend_release) begin
            pend_release = 1'b0;
            down = 1'b0;
            phase = PH_DONE;
            expected_q.push_back(make_point(KIND_POINT, cur_x, cur_y, 1'b0));
          end else if (pend_press) begin
            pend_press = 1'b0;
            cur_x = pend_x;
            cur_y = pend_y;
            down = 1'b1;
            age = '0;
            phase = PH_DONE;
            expected_q.push_back(make_point(KIND_POINT, cur_x, cur_y, 1'b1));
          end else begin
            fresh_press = 1'b0;
            phase = PH_OPEN;
          end
        end
        MODE_MESSAGE: begin
          if (!en || phase != PH_OPEN) begin
            expected_q.push_back(make_point(KIND_REFUSE, '0, '0, 1'b0));
          end else if (it.msg_id == touch_id) begin
            nx = {it.x_high, it.xy_low[7:4]};
            ny = {it.y_high, it.xy_low[3:0]};
            age = '0;
            if (it.status[ST_SUPPRESS]) begin
              down = 1'b0;
            end else if (it.status[ST_DETECT]) begin
              // a second press while down is held over to the next poll
              if (it.status[ST_PRESS] && down) begin
                down = 1'b0;
                pend_press = 1'b1;
                pend_x = nx;
                pend_y = ny;
                halt = 1'b1;
              end else begin
                cur_x = nx;
                cur_y = ny;
                if (!down) fresh_press = 1'b1;
                down = 1'b1;
              end
            end else if (it.status[ST_RELEASE]) begin
              if (fresh_press) begin
                pend_release = 1'b1;
                halt = 1'b1;
              end else begin
                down = 1'b0;
              end
            end
            if (halt) phase = PH_HALT;
          end
        end
        MODE_POLL_END: begin
          was = phase;
          phase = PH_IDLE;
          if (was == PH_OPEN || was == PH_HALT) begin
            if (down && age > stuck_limit) begin
              down = 1'b0;
              pend_release = 1'b0;
              pend_press = 1'b0;
            end
            expected_q.push_back(make_point(KIND_POINT, cur_x, cur_y, down));
          end
        end
        default: begin
          if (age != '1) age = age + 1'b1;
        end
      endcase
    endfunction

    function void check_result(point_t got);
      point_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind=%0d x=%0h y=%0h down=%0d",
                   got.kind, got.x, got.y, got.down);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp kind=%0d x=%0h y=%0h down=%0d",
                     want.kind, want.x, want.y, want.down,
                     ", got kind=%0d x=%0h y=%0h down=%0d",
                     got.kind, got.x, got.y, got.down);
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ENABLE;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_mode = MODE_TICK;
  logic [7:0]                in_msg_report_id = '0;
  logic [7:0]                in_status_byte = '0;
  logic [7:0]                in_x_high = '0;
  logic [7:0]                in_y_high = '0;
  logic [7:0]                in_xy_low = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_kind;
  logic [COORD_W-1:0]        out_point_x;
  logic [COORD_W-1:0]        out_point_y;
  logic                      out_point_down;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  touch_scoreboard sb = new();
  point_t          seen;
  msg_item_t       taken;

  touch_report_tracker i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_msg_report_id(in_msg_report_id),
    .in_status_byte (in_status_byte),
    .in_x_high      (in_x_high),
    .in_y_high      (in_y_high),
    .in_xy_low      (in_xy_low),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_down (out_point_down)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.kind = out_kind;
        seen.x = out_point_x;
        seen.y = out_point_y;
        seen.down = out_point_down;
        sb.check_result(seen);
      end
      if (in_valid && !in_stall) begin
        taken.mode = in_mode;
        taken.msg_id = in_msg_report_id;
        taken.status = in_status_byte;
        taken.x_high = in_x_high;
        taken.y_high = in_y_high;
        taken.xy_low = in_xy_low;
        sb.note_item(taken);
      end
    end
  end

  function automatic msg_item_t mk(logic [1:0] mode, logic [7:0] id, logic [7:0] st,
                                   logic [7:0] xh, logic [7:0] yh, logic [7:0] xl);
    msg_item_t it;
    it.mode = mode;
    it.msg_id = id;
    it.status = st;
    it.x_high = xh;
    it.y_high = yh;
    it.xy_low = xl;
    return it;
  endfunction

  // Random fields; messages mostly carry the touch id, and about half the items get biased flags.
  function automatic msg_item_t rand_item(logic [1:0] mode);
    msg_item_t it;
    it = mk(mode, 8'($urandom_range(255)), 8'($urandom_range(255)),
            8'($urandom_range(255)), 8'($urandom_range(255)),
            8'($urandom_range(255)));
    if (mode == MODE_MESSAGE && $urandom_range(9) != 0) it.msg_id = sb.touch_id;
    if ($urandom_range(1)) begin
      it.status[ST_DETECT]   = ($urandom_range(9) < 5);
      it.status[ST_PRESS]    = ($urandom_range(9) < 4);
      it.status[ST_RELEASE]  = ($urandom_range(9) < 3);
      it.status[ST_SUPPRESS] = ($urandom_range(9) == 0);
    end
    return it;
  endfunction

  task automatic send(input msg_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_msg_report_id <= it.msg_id;
    in_status_byte <= it.status;
    in_x_high <= it.x_high;
    in_y_high <= it.y_high;
    in_xy_low <= it.xy_low;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every report is back and the pipe has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic en_v, input logic [7:0] id_v,
                            input logic [15:0] lim_v);
    cfg_we <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_wdata <= {15'd0, en_v};
    @(posedge clk);
    cfg_index <= REG_TOUCH_ID;
    cfg_wdata <= {8'd0, id_v};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= lim_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(en_v, id_v, lim_v);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send(rand_item(MODE_TICK));
  endtask

  // Mostly well-formed polls with random content, some noise and cut-off polls.
  task automatic run_random(input int quota);
    int        sent;
    int        n_msgs;
    msg_item_t it;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) == 0) begin
        it = rand_item(2'($urandom_range(3)));
        send(it);
        if (it.mode != MODE_MESSAGE || it.msg_id == sb.touch_id) sent++;
      end else begin
        send(rand_item(MODE_POLL_BEGIN));
        sent++;
        n_msgs = $urandom_range(4);
        for (int k = 0; k < n_msgs; k++) begin
          if ($urandom_range(4) == 0) begin
            send(rand_item(MODE_TICK));
            sent++;
          end
          it = rand_item(MODE_MESSAGE);
          send(it);
          if (it.msg_id == sb.touch_id) sent++;
        end
        if ($urandom_range(19) != 0) begin
          send(rand_item(MODE_POLL_END));
          sent++;
        end
        n_msgs = $urandom_range(3) == 0 ? $urandom_range(1, 8) : $urandom_range(0, 2);
        send_ticks(n_msgs);
        sent += n_msgs;
      end
    end
  endtask

  initial begin
    logic        en_v;
    logic [7:0]  id_v;
    logic [15:0] lim_v;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: block disabled
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h01, 8'hC0, 8'h11, 8'h22, 8'h33));
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    settle();
    write_regs(1'b1, 8'd1, 16'd1000);

    send(mk(MODE_MESSAGE, 8'h01, 8'h80, 8'h01, 8'h01, 8'h01));   // no poll open
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h02, 8'h80, 8'h55, 8'h55, 8'h55));   // foreign id
    send(mk(MODE_MESSAGE, 8'h01, 8'hC0, 8'hFF, 8'hFF, 8'hFF));
    send(mk(MODE_MESSAGE, 8'h01, 8'h20, 8'h00, 8'h00, 8'h00));   // release after press
    send(mk(MODE_MESSAGE, 8'h01, 8'h80, 8'h10, 8'h10, 8'h10));   // intake halted
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // held release
    send(mk(MODE_MESSAGE, 8'h01, 8'h80, 8'h10, 8'h10, 8'h10));
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // restart poll
    send(mk(MODE_MESSAGE, 8'h01, 8'hC0, 8'h12, 8'h34, 8'h56));   // press while down
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)); // held press
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h01, 8'h20, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h01, 8'h82, 8'h77, 8'h77, 8'h77));   // suppress wins
    send(mk(MODE_MESSAGE, 8'h01, 8'h80, 8'hAB, 8'hCD, 8'hEF));
    send_ticks(3);
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    // zero timeout, top id: one tick is enough to force a release
    write_regs(1'b1, 8'd255, 16'd0);
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'hFF, 8'h80, 8'h80, 8'h7F, 8'h5A));
    send(mk(MODE_MESSAGE, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00));
    send_ticks(1);
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    // enable dropped while a poll is open
    write_regs(1'b1, 8'd0, 16'd65535);
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h00, 8'h80, 8'h3C, 8'hC3, 8'hA5));
    settle();
    write_regs(1'b0, 8'd0, 16'd65535);
    send(mk(MODE_MESSAGE, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    // press held across idle ticks: kept under the top timeout,
    // force-released once the age passes a smaller one
    write_regs(1'b1, 8'd0, 16'd65535);
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_MESSAGE, 8'h00, 8'h80, 8'h3C, 8'hC3, 8'hA5));
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_ticks(40);
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
    write_regs(1'b1, 8'd0, 16'd39);
    send(mk(MODE_POLL_BEGIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(MODE_POLL_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 58; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 58; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        settle();
        en_v = ($urandom_range(5) != 0);
        case ($urandom_range(3))
          0: id_v = 8'd0;
          1: id_v = 8'd255;
          default: id_v = 8'($urandom_range(255));
        endcase
        case ($urandom_range(5))
          0: lim_v = 16'd0;
          1: lim_v = 16'hFFFF;
          default: lim_v = 16'($urandom_range(1, 12));
        endcase
        write_regs(en_v, id_v, lim_v);
        run_random(56);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

/* files.f */
rtl/trt_pkg.sv
rtl/trt_decode.sv
rtl/trt_core.sv
rtl/trt_outbuf.sv
rtl/touch_report_tracker.sv
test/tb.sv
